/* rtl/cbec_pkg.sv */
// Shared constants and types for the bit-serial CRC encoder and checker.
`timescale 1ns / 1ps
`default_nettype none
package cbec_pkg;

  // Default of the remainder register width
  localparam int MAX_DEGREE_DEF = 32;

  // Fixed widths of the configuration registers and port
  localparam int TAPS_W     = 32;
  localparam int DEG_CFG_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Stream data widths (fields padded up to whole bytes)
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [TAPS_W-1:0]    TAPS_RST   = 32'd3;
  localparam logic [DEG_CFG_W-1:0] DEGREE_RST = 6'd3;
  localparam logic                 MODE_RST   = 1'b0;

  // Operation codes assigned by the front
  localparam logic [1:0] OP_PASS    = 2'd0;  // encode, data bit out
  localparam logic [1:0] OP_TAIL    = 2'd1;  // encode, last data bit, then remainder
  localparam logic [1:0] OP_DIV     = 2'd2;  // check, divide only
  localparam logic [1:0] OP_VERDICT = 2'd3;  // check, last bit, give verdict

  // Result kinds
  localparam logic KIND_CODE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // One queue entry from front to back
  typedef struct packed {
    logic [1:0] op;
    logic       data_bit;
  } cbec_entry_t;

endpackage
`default_nettype wire

/* rtl/cbec_front.sv */
// Front end: accepts input bits, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module cbec_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_data_bit,
  input  wire logic                  in_last,
  input  wire logic                  check_mode,
  output logic                       q_valid,
  output cbec_pkg::cbec_entry_t      q_entry,
  input  wire logic                  q_pop
);

  localparam int PTR_W = $clog2(cbec_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cbec_pkg::QUEUE_DEPTH + 1);

  cbec_pkg::cbec_entry_t queue_r [cbec_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  cbec_pkg::cbec_entry_t new_entry;

  // Classify the incoming bit by mode and end of message
  always_comb begin
    new_entry.data_bit = in_data_bit;
    if (check_mode) begin
      new_entry.op = in_last ? cbec_pkg::OP_VERDICT : cbec_pkg::OP_DIV;
    end else begin
      new_entry.op = in_last ? cbec_pkg::OP_TAIL : cbec_pkg::OP_PASS;
    end
  end

  assign in_ready = (count_r != CNT_W'(cbec_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = queue_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified entry
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule
`default_nettype wire

/* rtl/cbec_back.sv */
// Back end: remainder register, zero padding and remainder send-out, output register.
`timescale 1ns / 1ps
`default_nettype none
module cbec_back #(
  parameter int MAX_DEGREE = cbec_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire cbec_pkg::cbec_entry_t           q_entry,
  output logic                                 q_pop,
  input  wire logic [cbec_pkg::TAPS_W-1:0]     taps,
  input  wire logic [cbec_pkg::DEG_CFG_W-1:0]  degree,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_kind,
  output logic                                 out_code_bit,
  output logic                                 out_last,
  output logic                                 out_check_ok
);

  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  localparam logic [1:0] PH_RUN  = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_SEND = 2'd2;

  typedef struct packed {
    logic kind;
    logic code_bit;
    logic code_last;
    logic check_ok;
  } result_t;

  logic [MAX_DEGREE-1:0] rem_r, rem_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [DEG_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               res_r, res_nxt;
  logic                  load;
  logic                  can_out;

  logic [DEG_W-1:0]      eff_deg;
  logic [IDX_W-1:0]      top_idx;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] taps_ext;
  logic                  top_bit;
  logic                  step_bit;
  logic [MAX_DEGREE-1:0] stepped;
  logic [MAX_DEGREE-1:0] shifted_out;

  // Clamp the degree to 1..MAX_DEGREE
  always_comb begin
    if (degree == '0) begin
      eff_deg = DEG_W'(1);
    end else if (32'(degree) > 32'(MAX_DEGREE)) begin
      eff_deg = DEG_W'(MAX_DEGREE);
    end else begin
      eff_deg = DEG_W'(degree);
    end
  end

  assign top_idx = IDX_W'(eff_deg - 1'b1);

  // Build the degree mask
  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i] = (32'(i) < 32'(eff_deg));
    end
  end

  assign taps_ext = MAX_DEGREE'({{MAX_DEGREE{1'b0}}, taps});
  assign top_bit  = rem_r[top_idx];
  assign step_bit = (phase_r == PH_RUN) ? q_entry.data_bit : 1'b0;

  // One long-division step: shift in a bit, subtract the generator on a carry out
  assign stepped = (((rem_r << 1) | MAX_DEGREE'(step_bit)) & mask)
                   ^ (top_bit ? (taps_ext & mask) : '0);
  assign shifted_out = (rem_r << 1) & mask;

  assign can_out = !out_valid_r || out_ready;

  // Sequence the work of each queued bit
  always_comb begin
    rem_nxt   = rem_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    load      = 1'b0;
    q_pop     = 1'b0;
    case (phase_r)
      PH_RUN: begin
        if (q_valid && can_out) begin
          q_pop = 1'b1;
          case (q_entry.op)
            cbec_pkg::OP_PASS: begin
              rem_nxt = stepped;
              load    = 1'b1;
              res_nxt = '{kind: cbec_pkg::KIND_CODE, code_bit: q_entry.data_bit,
                          code_last: 1'b0, check_ok: 1'b0};
            end
            cbec_pkg::OP_TAIL: begin
              rem_nxt   = stepped;
              load      = 1'b1;
              res_nxt   = '{kind: cbec_pkg::KIND_CODE, code_bit: q_entry.data_bit,
                            code_last: 1'b0, check_ok: 1'b0};
              phase_nxt = PH_PAD;
              cnt_nxt   = eff_deg;
            end
            cbec_pkg::OP_DIV: begin
              rem_nxt = stepped;
            end
            cbec_pkg::OP_VERDICT: begin
              rem_nxt = '0;
              load    = 1'b1;
              res_nxt = '{kind: cbec_pkg::KIND_VERDICT, code_bit: 1'b0,
                          code_last: 1'b1, check_ok: (stepped == '0)};
            end
            default: begin
              rem_nxt = stepped;
            end
          endcase
        end
      end
      PH_PAD: begin
        // Feed one zero of padding per cycle
        rem_nxt = stepped;
        cnt_nxt = DEG_W'(cnt_r - 1'b1);
        if (cnt_r == DEG_W'(1)) begin
          phase_nxt = PH_SEND;
          cnt_nxt   = eff_deg;
        end
      end
      PH_SEND: begin
        // Send the remainder most significant bit first
        if (can_out) begin
          load    = 1'b1;
          res_nxt = '{kind: cbec_pkg::KIND_CODE, code_bit: top_bit,
                      code_last: (cnt_r == DEG_W'(1)), check_ok: 1'b0};
          rem_nxt = shifted_out;
          cnt_nxt = DEG_W'(cnt_r - 1'b1);
          if (cnt_r == DEG_W'(1)) begin
            phase_nxt = PH_RUN;
            rem_nxt   = '0;
          end
        end
      end
      default: begin
        phase_nxt = PH_RUN;
      end
    endcase
  end

  // Hold or drop the output register
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      phase_r     <= PH_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = res_r.kind;
  assign out_code_bit = res_r.code_bit;
  assign out_last     = res_r.code_last;
  assign out_check_ok = res_r.check_ok;

endmodule
`default_nettype wire

/* rtl/crc_bitserial_encode_check.sv */
// Top level of the bit-serial CRC encoder and checker with programmable generator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | slave     | in_tvalid/in_tready  | tdata[0] data_bit, tlast last
//  out     | master    | out_tvalid/out_tready| tdata[0] code_bit, tdata[1] check_ok,
//          |           |                      | tlast code_last, tuser result_kind
//  cfg     | slave     | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// One input bit per cycle is taken while the queue has room and divided by the remainder register.
// In an encode message with degree d, the last bit starts zero padding with d zeros
// and then the send of the d remainder bits.
// A four-entry queue keeps accepting bits while the back end pads or sends.
// Synchronous active-low reset clears the remainder, queue and output register.
`timescale 1ns / 1ps
`default_nettype none
module crc_bitserial_encode_check #(
  parameter int MAX_DEGREE = cbec_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [cbec_pkg::IN_DATA_W-1:0]    in_tdata,   // [0] data_bit
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [cbec_pkg::OUT_DATA_W-1:0]        out_tdata,  // [0] code_bit, [1] check_ok
  output logic                                   out_tlast,
  output logic                                   out_tuser,  // [0] result_kind
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cbec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cbec_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [cbec_pkg::TAPS_W-1:0]    taps_r;
  logic [cbec_pkg::DEG_CFG_W-1:0] degree_r;
  logic                           mode_r;
  logic                           q_valid;
  logic                           q_pop;
  cbec_pkg::cbec_entry_t          q_entry;
  logic                           out_code_bit;
  logic                           out_check_ok;

  assign cfg_ready = 1'b1;

  // Take configuration transfers; ignore indexes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r   <= cbec_pkg::TAPS_RST;
      degree_r <= cbec_pkg::DEGREE_RST;
      mode_r   <= cbec_pkg::MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbec_pkg::REG_TAPS:   taps_r   <= cfg_data[cbec_pkg::TAPS_W-1:0];
        cbec_pkg::REG_DEGREE: degree_r <= cfg_data[cbec_pkg::DEG_CFG_W-1:0];
        cbec_pkg::REG_MODE:   mode_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  cbec_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_data_bit (in_tdata[0]),
    .in_last     (in_tlast),
    .check_mode  (mode_r),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop)
  );

  cbec_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .taps         (taps_r),
    .degree       (degree_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_tuser),
    .out_code_bit (out_code_bit),
    .out_last     (out_tlast),
    .out_check_ok (out_check_ok)
  );

  assign out_tdata = {{(cbec_pkg::OUT_DATA_W-2){1'b0}}, out_check_ok, out_code_bit};

endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the bit-serial CRC encoder and checker.
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 80;   // queue plus padding and send of a full remainder
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 12;
  localparam logic [cbec_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic result_kind;
    logic code_bit;
    logic code_last;
    logic check_ok;
  } crc_result_t;

  // Predict codeword bits and verdicts from accepted bits and register writes
  class crc_scoreboard;
    logic [cbec_pkg::TAPS_W-1:0]    taps;
    logic [cbec_pkg::DEG_CFG_W-1:0] degree;
    logic                           check_mode;
    logic [31:0]                    remainder;
    crc_result_t                    expected[$];
    int                             errors;

    function new();
      taps       = cbec_pkg::TAPS_RST;
      degree     = cbec_pkg::DEGREE_RST;
      check_mode = cbec_pkg::MODE_RST;
      remainder  = '0;
      errors     = 0;
    endfunction

    // Clamp the programmed degree to 1..MAX_DEGREE
    function int unsigned span();
      if (degree == 0) return 1;
      if (degree > cbec_pkg::MAX_DEGREE_DEF) return cbec_pkg::MAX_DEGREE_DEF;
      return degree;
    endfunction

    function logic [31:0] mask_of(int unsigned d);
      logic [63:0] m;
      m = (64'd1 << d) - 64'd1;
      return m[31:0];
    endfunction

    // Shift one bit into the remainder, subtract the generator on carry out
    function logic [31:0] divide(logic [31:0] r, int unsigned d, logic b);
      logic [31:0] m;
      logic        top;
      m   = mask_of(d);
      top = r[d-1];
      r   = ((r << 1) | {31'b0, b}) & m;
      if (top) r = r ^ (taps & m);
      return r;
    endfunction

    // Remainder of an n-bit message (MSB first) padded with zeros
    function logic [31:0] crc_of(logic [127:0] w, int n);
      logic [31:0] r;
      int unsigned d;
      r = '0;
      d = span();
      for (int i = n - 1; i >= 0; i--) r = divide(r, d, w[i]);
      for (int i = 0; i < d; i++) r = divide(r, d, 1'b0);
      return r;
    endfunction

    function void write_reg(logic [cbec_pkg::CFG_IDX_W-1:0] idx,
                            logic [cbec_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        cbec_pkg::REG_TAPS:   taps = value;
        cbec_pkg::REG_DEGREE: degree = value[cbec_pkg::DEG_CFG_W-1:0];
        cbec_pkg::REG_MODE:   check_mode = value[0];
        default: ;
      endcase
    endfunction

    function void take_bit(logic b, logic l);
      int unsigned d;
      crc_result_t r;
      d = span();
      remainder = divide(remainder & mask_of(d), d, b);
      if (check_mode) begin
        if (l) begin
          r = '{cbec_pkg::KIND_VERDICT, 1'b0, 1'b1, remainder == '0};
          expected.push_back(r);
          remainder = '0;
        end
        return;
      end
      r = '{cbec_pkg::KIND_CODE, b, 1'b0, 1'b0};
      expected.push_back(r);
      if (l) begin
        for (int i = 0; i < d; i++) remainder = divide(remainder, d, 1'b0);
        for (int i = 0; i < d; i++) begin
          r = '{cbec_pkg::KIND_CODE, remainder[d-1-i], i == d - 1, 1'b0};
          expected.push_back(r);
        end
        remainder = '0;
      end
    endfunction

    function void check_result(crc_result_t got);
      crc_result_t e;
      if (expected.size() == 0) begin
        $error("unexpected result: result_kind %0b code_bit %0b code_last %0b check_ok %0b",
               got.result_kind, got.code_bit, got.code_last, got.check_ok);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (e.result_kind !== got.result_kind) begin
        $error("result_kind: expected %0b, got %0b", e.result_kind, got.result_kind);
        errors++;
      end
      if (e.code_bit !== got.code_bit) begin
        $error("code_bit: expected %0b, got %0b", e.code_bit, got.code_bit);
        errors++;
      end
      if (e.code_last !== got.code_last) begin
        $error("code_last: expected %0b, got %0b", e.code_last, got.code_last);
        errors++;
      end
      if (e.check_ok !== got.check_ok) begin
        $error("check_ok: expected %0b, got %0b", e.check_ok, got.check_ok);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [cbec_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [cbec_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [cbec_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cbec_pkg::CFG_DATA_W-1:0] cfg_data;

  crc_scoreboard board = new();
  bit send_calm;
  bit recv_calm;
  int cycles = 0;

  crc_bitserial_encode_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Drive one bit transfer; enter and leave at a falling edge
  task automatic send_bit(input logic b, input logic l);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(cbec_pkg::IN_DATA_W-1){1'b0}}, b};
    in_tlast  = l;
    do @(posedge clk); while (!in_tready);
    board.take_bit(b, l);
    @(negedge clk);
  endtask

  // Send the low n bits of w, most significant first
  task automatic send_word(input logic [127:0] w, input int n, input bit close);
    for (int i = n - 1; i >= 0; i--) send_bit(w[i], close && i == 0);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [cbec_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cbec_pkg::CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_results();
    while (board.expected.size() != 0) @(negedge clk);
  endtask

  // Hold off until the block has gone quiet
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Accept results with random stalls, calm stretches now and then
  initial begin
    crc_result_t got;
    int taken;
    int stall;
    taken     = 0;
    recv_calm = 1'b0;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = '{out_tuser, out_tdata[0], out_tlast, out_tdata[1]};
      board.check_result(got);
      taken++;
      if (taken % 40 == 0) recv_calm = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  initial begin
    logic [127:0]                   w;
    logic [31:0]                    crc;
    logic [31:0]                    junk;
    logic [cbec_pkg::DEG_CFG_W-1:0] deg;
    logic [cbec_pkg::TAPS_W-1:0]    taps_v;
    logic                           mode;
    int unsigned                    d;
    int                             len;
    int                             sent;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = cbec_pkg::REG_TAPS;
    cfg_data  = '0;
    send_calm = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: a message shorter than the generator, then pause for all results
    send_word(128'b1, 1, 1'b1);
    wait_results();
    send_word(128'b0110, 4, 1'b1);

    // Degree zero acts as one; all taps set
    settle();
    write_reg(cbec_pkg::REG_TAPS, '1);
    write_reg(cbec_pkg::REG_DEGREE, '0);
    send_word(128'b11, 2, 1'b1);

    // Degree above the maximum acts as the maximum
    settle();
    write_reg(cbec_pkg::REG_DEGREE, 32'hFFFF_FFFF);
    write_reg(cbec_pkg::REG_TAPS, 32'h04C1_1DB7);
    send_word(128'b10, 2, 1'b1);

    // Write to an unused index must change nothing
    settle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_word(128'b0, 1, 1'b1);

    // Check mode: good codeword, corrupted codeword, codewords shorter than the generator
    settle();
    write_reg(cbec_pkg::REG_MODE, 32'd1);
    write_reg(cbec_pkg::REG_DEGREE, 32'd5);
    write_reg(cbec_pkg::REG_TAPS, 32'h05);
    crc = board.crc_of(128'b10, 2);
    w   = (128'b10 << 5) | crc;
    send_word(w, 7, 1'b1);
    send_word(w ^ 128'h08, 7, 1'b1);
    send_word(128'b0, 1, 1'b1);
    send_word(128'b1, 1, 1'b1);

    // Random phases, each under its own register settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      junk = $urandom();
      case ($urandom_range(0, 5))
        0:       deg = 6'd0;
        1:       deg = 6'd1;
        2:       deg = 6'd32;
        3:       deg = $urandom_range(33, 63);
        default: deg = $urandom_range(2, 31);
      endcase
      case ($urandom_range(0, 3))
        0:       taps_v = '0;
        1:       taps_v = '1;
        default: taps_v = $urandom();
      endcase
      mode = $urandom_range(0, 1);
      if (p == 0) begin
        deg = 6'd1;
        taps_v = '0;
        mode = 1'b0;
      end else if (p == 1) begin
        deg = 6'd32;
        taps_v = '1;
        mode = 1'b1;
      end
      if (p < 2 || $urandom_range(0, 3) != 0) write_reg(cbec_pkg::REG_TAPS, taps_v);
      if (p < 2 || $urandom_range(0, 3) != 0)
        write_reg(cbec_pkg::REG_DEGREE, {($urandom_range(0, 1) ? junk[31:6] : 26'd0), deg});
      if (p < 2 || $urandom_range(0, 3) != 0)
        write_reg(cbec_pkg::REG_MODE, {($urandom_range(0, 1) ? junk[31:1] : 31'd0), mode});
      if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, $urandom());
      send_calm = ($urandom_range(0, 3) == 0);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        w   = {$urandom(), $urandom(), $urandom(), $urandom()};
        // Mostly well-formed codewords in check mode, some with one bit flipped
        if (board.check_mode && $urandom_range(0, 4) != 0) begin
          d   = board.span();
          crc = board.crc_of(w, len);
          w   = (w << d) | crc;
          len = len + d;
          if ($urandom_range(0, 5) == 0) w[$urandom_range(0, len - 1)] ^= 1'b1;
        end
        send_word(w, len, 1'b1);
        sent = sent + len;
        if ($urandom_range(0, 9) == 0) wait_results();
      end
      // Leave a message open across the next register writes
      if ($urandom_range(0, 3) == 0) send_word({96'd0, $urandom()}, $urandom_range(1, 5), 1'b0);
    end

    settle();
    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
